// ===== rtl/core/tcw_pkg.sv =====
// Shared types, constants and opcodes for the text console character writer.
package tcw_pkg;

   // Default screen geometry
   localparam int COLUMNS_DEF   = 80;
   localparam int ROWS_DEF      = 25;
   localparam int TAB_WIDTH_DEF = 8;

   // Cell and attribute values
   localparam logic [7:0]  ATTR_RESET = 8'h0F;
   localparam logic [15:0] CELL_RESET = 16'h0F20;

   // Character codes with special handling
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_LAST  = 8'hFF;

   // Request opcodes
   typedef enum logic [1:0] {
      OP_PUT   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_READ  = 2'd2
   } op_type;

   // Request transfer
   typedef struct packed {
      logic [1:0]  opcode;
      logic [7:0]  char_code;
      logic [10:0] cell_index;
   } req_type;

   // Response transfer
   typedef struct packed {
      logic [10:0] cursor_offset;
      logic [6:0]  cursor_column;
      logic [4:0]  cursor_row;
      logic [15:0] cell_value;
   } rsp_type;

endpackage

// ===== rtl/core/text_console_char_writer_top.sv =====
// Top level of the text console character writer: sequencer, cursor and screen store.
//
//   channel   ports                          direction  flow control
//   request   start, busy, req_item          in         taken when start && !busy
//   response  rsp_strobe, rsp_item           out        one-cycle strobe, no stall
//   config    csr_wr_en, csr_wr_data         in         written when csr_wr_en
//
// Put character (ST_DONE) and read cell (ST_READ) keep busy high; the response strobes in
// the same cycle that busy drops. Clear screen keeps busy high through ST_FILL and ST_DONE.
// A put that scrolls adds ST_SCROLL, ST_DRAIN and ST_FILL: one pass of the single RAM port pair
// copying rows up, then the bottom row refill. After reset a clearing pass writes every
// cell (2000 by default) with busy high. Responses cannot be stalled.
module text_console_char_writer_top #(
   parameter int COLUMNS   = tcw_pkg::COLUMNS_DEF,
   parameter int ROWS      = tcw_pkg::ROWS_DEF,
   parameter int TAB_WIDTH = tcw_pkg::TAB_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  tcw_pkg::req_type req_item,
   output logic             rsp_strobe,
   output tcw_pkg::rsp_type rsp_item,
   input  logic             csr_wr_en,
   input  logic [7:0]       csr_wr_data
);

   import tcw_pkg::*;

   localparam int CELLS  = COLUMNS * ROWS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int NCOL_W = $clog2(COLUMNS + TAB_WIDTH);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int PH_W   = $clog2(TAB_WIDTH);

   typedef enum logic [6:0] {
      ST_INIT   = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_READ   = 7'b0000100,
      ST_SCROLL = 7'b0001000,
      ST_DRAIN  = 7'b0010000,
      ST_FILL   = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  ptr_ff, ptr_in;
   logic               copy_wr_en_ff, copy_wr_en_in;
   logic [ADDR_W-1:0]  copy_wr_addr_ff, copy_wr_addr_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [PH_W-1:0]    phase_ff, phase_in;
   logic [7:0]         attr_ff;
   logic               idx_ok_ff, idx_ok_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   rsp_type            rsp_ff, rsp_in;

   logic               accept;
   logic [NCOL_W-1:0]  ncol;
   logic [PH_W-1:0]    nphase;
   logic               row_inc;
   logic [31:0]        pos_wide;
   logic [31:0]        idx_wide;
   logic [31:0]        off_wide;
   logic [31:0]        col_wide;
   logic [31:0]        row_wide;

   logic               ram_wr_en;
   logic [ADDR_W-1:0]  ram_wr_addr;
   logic [15:0]        ram_wr_data;
   logic               ram_rd_en;
   logic [ADDR_W-1:0]  ram_rd_addr;
   logic [15:0]        ram_rd_data;

   assign accept   = start && (state_ff == ST_IDLE);
   assign busy     = (state_ff != ST_IDLE);
   assign pos_wide = 32'(row_ff) * 32'(COLUMNS) + 32'(col_ff);
   assign idx_wide = 32'(req_item.cell_index);
   assign col_wide = 32'(col_ff);
   assign row_wide = 32'(row_ff);
   assign off_wide = pos_wide;

   // Screen store
   tcw_ram #(
      .WIDTH (16),
      .DEPTH (CELLS)
   ) u_screen (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Cursor update for a put character request
   always_comb begin
      ncol    = NCOL_W'(col_ff);
      nphase  = phase_ff;
      row_inc = 1'b0;
      case (req_item.char_code)
         CH_BS: begin
            if (col_ff != '0) begin
               ncol   = NCOL_W'(col_ff) - NCOL_W'(1);
               nphase = (phase_ff == '0) ? PH_W'(TAB_WIDTH - 1) : phase_ff - PH_W'(1);
            end
         end
         CH_TAB: begin
            ncol   = NCOL_W'(col_ff) + NCOL_W'(TAB_WIDTH) - NCOL_W'(phase_ff);
            nphase = '0;
         end
         CH_CR: begin
            ncol   = '0;
            nphase = '0;
         end
         CH_LF: begin
            ncol    = '0;
            nphase  = '0;
            row_inc = 1'b1;
         end
         default: begin
            if (req_item.char_code inside {[CH_SPACE:CH_LAST]}) begin
               ncol   = NCOL_W'(col_ff) + NCOL_W'(1);
               nphase = (phase_ff == PH_W'(TAB_WIDTH - 1)) ? '0 : phase_ff + PH_W'(1);
            end
         end
      endcase
      // Column wrap to the next row
      if (ncol >= NCOL_W'(COLUMNS)) begin
         ncol    = '0;
         nphase  = '0;
         row_inc = 1'b1;
      end
   end

   // Sequencer and RAM port steering
   always_comb begin
      state_in        = state_ff;
      ptr_in          = ptr_ff;
      copy_wr_en_in   = 1'b0;
      copy_wr_addr_in = ptr_ff - ADDR_W'(COLUMNS);
      col_in          = col_ff;
      row_in          = row_ff;
      phase_in        = phase_ff;
      idx_ok_in       = idx_ok_ff;
      rsp_strobe_in   = 1'b0;
      rsp_in          = rsp_ff;
      ram_wr_en       = 1'b0;
      ram_wr_addr     = ptr_ff;
      ram_wr_data     = {attr_ff, CH_SPACE};
      ram_rd_en       = 1'b0;
      ram_rd_addr     = ptr_ff;

      case (state_ff)
         ST_INIT: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = CELL_RESET;
            ptr_in      = ptr_ff + ADDR_W'(1);
            if (ptr_ff == ADDR_W'(CELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_item.opcode)
                  OP_PUT: begin
                     // printable codes land at the cursor before it moves
                     if (req_item.char_code inside {[CH_SPACE:CH_LAST]}) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = pos_wide[ADDR_W-1:0];
                        ram_wr_data = {attr_ff, req_item.char_code};
                     end
                     col_in   = ncol[COL_W-1:0];
                     phase_in = nphase;
                     state_in = ST_DONE;
                     if (row_inc) begin
                        if (row_ff == ROW_W'(ROWS - 1)) begin
                           ptr_in   = ADDR_W'(COLUMNS);
                           state_in = ST_SCROLL;
                        end else begin
                           row_in = row_ff + ROW_W'(1);
                        end
                     end
                  end
                  OP_CLEAR: begin
                     col_in   = '0;
                     row_in   = '0;
                     phase_in = '0;
                     ptr_in   = '0;
                     state_in = ST_FILL;
                  end
                  OP_READ: begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = idx_wide[ADDR_W-1:0];
                     idx_ok_in   = (idx_wide < 32'(CELLS));
                     state_in    = ST_READ;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_strobe_in        = 1'b1;
            rsp_in.cursor_offset = off_wide[10:0];
            rsp_in.cursor_column = col_wide[6:0];
            rsp_in.cursor_row    = row_wide[4:0];
            rsp_in.cell_value    = idx_ok_ff ? ram_rd_data : 16'h0000;
            state_in             = ST_IDLE;
         end
         ST_SCROLL: begin
            // read one row ahead, write the data back in the following cycle
            ram_rd_en     = 1'b1;
            ram_wr_en     = copy_wr_en_ff;
            ram_wr_addr   = copy_wr_addr_ff;
            ram_wr_data   = ram_rd_data;
            copy_wr_en_in = 1'b1;
            ptr_in        = ptr_ff + ADDR_W'(1);
            if (ptr_ff == ADDR_W'(CELLS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            ram_wr_en   = copy_wr_en_ff;
            ram_wr_addr = copy_wr_addr_ff;
            ram_wr_data = ram_rd_data;
            ptr_in      = ADDR_W'(CELLS - COLUMNS);
            state_in    = ST_FILL;
         end
         ST_FILL: begin
            ram_wr_en = 1'b1;
            ptr_in    = ptr_ff + ADDR_W'(1);
            if (ptr_ff == ADDR_W'(CELLS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            rsp_strobe_in        = 1'b1;
            rsp_in.cursor_offset = off_wide[10:0];
            rsp_in.cursor_column = col_wide[6:0];
            rsp_in.cursor_row    = row_wide[4:0];
            rsp_in.cell_value    = 16'h0000;
            state_in             = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         ptr_ff        <= '0;
         copy_wr_en_ff <= 1'b0;
         col_ff        <= '0;
         row_ff        <= '0;
         phase_ff      <= '0;
         attr_ff       <= ATTR_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ptr_ff        <= ptr_in;
         copy_wr_en_ff <= copy_wr_en_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         phase_ff      <= phase_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_wr_en) begin
            attr_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      copy_wr_addr_ff <= copy_wr_addr_in;
      idx_ok_ff       <= idx_ok_in;
      rsp_ff          <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   // Response strobes never fall in back-to-back cycles
   assert property (@(posedge clock) disable iff (reset) rsp_strobe |=> !rsp_strobe)
      else $error("back-to-back response strobes");

   // An accepted request always makes the block busy
   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> busy)
      else $error("request transfer did not raise busy");

   // Cursor stays on the screen
   assert property (@(posedge clock) disable iff (reset)
      (32'(row_ff) < 32'(ROWS)) && (32'(col_ff) < 32'(COLUMNS)))
      else $error("cursor outside the screen");

   // The clearing pass holds requests off right after reset
   assert property (@(posedge clock) $fell(reset) |-> busy)
      else $error("not busy after reset");

endmodule

// ===== rtl/core/tcw_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Storage write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
